/* design/tlvp_pkg.sv */
// Shared types, codes and constants for the TLV metadata record parser.
// No dependencies; used by every module of the block.
package tlvp_pkg;

  // Field widths of one result transaction
  localparam int TYPE_W   = 16;
  localparam int SIZE_W   = 16;
  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 16;
  localparam int REASON_W = 2;

  // Output queue depth (two slots must be free before a byte is taken)
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Highest type number with a fixed-width value
  localparam logic [TYPE_W-1:0] LAST_KNOWN_TYPE = 16'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

  // Parse phase
  typedef enum logic [2:0] {
    PH_H0  = 3'd0,  // type high byte
    PH_H1  = 3'd1,  // type low byte
    PH_H2  = 3'd2,  // size high byte
    PH_H3  = 3'd3,  // size low byte
    PH_PAY = 3'd4   // payload bytes
  } phase_t;

  // Result kinds
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // End reasons
  localparam logic [REASON_W-1:0] REASON_END_MARKER = 2'd0;
  localparam logic [REASON_W-1:0] REASON_USED_UP    = 2'd1;
  localparam logic [REASON_W-1:0] REASON_TRUNCATED  = 2'd2;
  localparam logic [REASON_W-1:0] REASON_MALFORMED  = 2'd3;

  // One result transaction
  typedef struct packed {
    logic                kind;
    logic [TYPE_W-1:0]   record_type;
    logic [SIZE_W-1:0]   declared_size;
    logic [VALUE_W-1:0]  value;
    logic                known_type;
    logic [COUNT_W-1:0]  record_count;
    logic [REASON_W-1:0] end_reason;
    logic                final_res;
  } res_t;

  // Up to two results caused by one input byte, first in r0
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  // Fixed value width in bytes for known types, 0 otherwise
  function automatic logic [3:0] fixed_width(input logic [TYPE_W-1:0] t);
    logic [3:0] w;
    begin
      case (t)
        16'd1, 16'd2, 16'd3, 16'd6, 16'd9: w = 4'd4;
        16'd4, 16'd5:                      w = 4'd8;
        16'd7, 16'd8, 16'd10:              w = 4'd2;
        default:                           w = 4'd0;
      endcase
      return w;
    end
  endfunction

endpackage

/* design/tlvp_parser.sv */
// Byte-wise TLV parse state: header assembly, value capture, record count.
// Produces up to two results per accepted byte. Depends on tlvp_pkg.
module tlvp_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic [7:0]         data_byte,
  input  logic               buffer_end,
  output tlvp_pkg::push_t    push
);

  tlvp_pkg::phase_t                  phase, phase_next;
  logic [tlvp_pkg::SIZE_W-1:0]       byte_counter, byte_counter_next;
  logic [tlvp_pkg::TYPE_W-1:0]       type_reg, type_reg_next;
  logic [tlvp_pkg::SIZE_W-1:0]       size_reg, size_reg_next;
  logic [tlvp_pkg::VALUE_W-1:0]      value_acc, value_acc_next;
  logic [tlvp_pkg::COUNT_W-1:0]      count_reg, count_reg_next;
  logic                              stopped, stopped_next;

  logic [3:0]                        width;
  logic                              known;
  logic                              rec_v, sum_v, ended;
  logic [tlvp_pkg::REASON_W-1:0]     reason;
  logic [tlvp_pkg::COUNT_W-1:0]      count_after;
  logic [tlvp_pkg::SIZE_W-1:0]       size_full, bc_inc;
  tlvp_pkg::res_t                    rec, sum;

  assign width = tlvp_pkg::fixed_width(type_reg);
  assign known = (type_reg != '0) && (type_reg <= tlvp_pkg::LAST_KNOWN_TYPE);
  assign size_full = {size_reg[15:8], data_byte};
  assign bc_inc = byte_counter + 16'd1;

  // Next state and result selection
  always_comb begin
    phase_next        = phase;
    byte_counter_next = byte_counter;
    type_reg_next     = type_reg;
    size_reg_next     = size_reg;
    value_acc_next    = value_acc;
    count_reg_next    = count_reg;
    stopped_next      = stopped;
    rec_v             = 1'b0;
    sum_v             = 1'b0;
    ended             = 1'b0;
    reason            = tlvp_pkg::REASON_END_MARKER;
    count_after       = count_reg;
    if (in_fire) begin
      if (stopped) begin
        // Drain the rest of the buffer silently
        if (buffer_end) begin
          phase_next     = tlvp_pkg::PH_H0;
          count_reg_next = '0;
          stopped_next   = 1'b0;
        end
      end else begin
        unique case (phase)
          tlvp_pkg::PH_H1: begin
            type_reg_next = {type_reg[15:8], data_byte};
            phase_next    = tlvp_pkg::PH_H2;
          end
          tlvp_pkg::PH_H2: begin
            size_reg_next = {data_byte, 8'h00};
            phase_next    = tlvp_pkg::PH_H3;
          end
          tlvp_pkg::PH_H3: begin
            size_reg_next     = size_full;
            byte_counter_next = '0;
            value_acc_next    = '0;
            if (type_reg == '0) begin
              ended  = 1'b1;
              reason = tlvp_pkg::REASON_END_MARKER;
            end else if (size_full < {12'd0, width}) begin
              ended  = 1'b1;
              reason = tlvp_pkg::REASON_MALFORMED;
            end else if (size_full == '0) begin
              rec_v      = 1'b1;
              phase_next = tlvp_pkg::PH_H0;
            end else begin
              phase_next = tlvp_pkg::PH_PAY;
            end
          end
          tlvp_pkg::PH_PAY: begin
            // Big-endian value capture over the first width bytes
            if (byte_counter < {12'd0, width}) begin
              value_acc_next = {value_acc[55:0], data_byte};
            end
            byte_counter_next = bc_inc;
            if (bc_inc == size_reg) begin
              rec_v      = 1'b1;
              phase_next = tlvp_pkg::PH_H0;
            end
          end
          default: begin
            type_reg_next = {data_byte, 8'h00};
            size_reg_next = '0;
            phase_next    = tlvp_pkg::PH_H1;
          end
        endcase

        // Saturating record count
        if (rec_v && (count_reg != tlvp_pkg::COUNT_MAX)) begin
          count_after = count_reg + 16'd1;
        end
        count_reg_next = count_after;

        if (!ended && buffer_end) begin
          ended  = 1'b1;
          reason = (phase_next == tlvp_pkg::PH_H0) ? tlvp_pkg::REASON_USED_UP
                                                   : tlvp_pkg::REASON_TRUNCATED;
        end

        if (ended) begin
          sum_v = 1'b1;
          if (buffer_end) begin
            phase_next     = tlvp_pkg::PH_H0;
            count_reg_next = '0;
            stopped_next   = 1'b0;
          end else begin
            stopped_next = 1'b1;
          end
        end
      end
    end
  end

  // Result records
  always_comb begin
    rec               = '0;
    rec.kind          = tlvp_pkg::KIND_RECORD;
    rec.record_type   = type_reg;
    rec.declared_size = size_reg_next;
    rec.value         = known ? value_acc_next : '0;
    rec.known_type    = known;

    sum               = '0;
    sum.kind          = tlvp_pkg::KIND_SUMMARY;
    sum.record_count  = count_after;
    sum.end_reason    = reason;
    sum.final_res     = 1'b1;

    push.v0 = rec_v | sum_v;
    push.v1 = rec_v & sum_v;
    push.r0 = rec_v ? rec : sum;
    push.r1 = sum;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tlvp_pkg::PH_H0;
      byte_counter <= '0;
      type_reg     <= '0;
      size_reg     <= '0;
      value_acc    <= '0;
      count_reg    <= '0;
      stopped      <= 1'b0;
    end else begin
      phase        <= phase_next;
      byte_counter <= byte_counter_next;
      type_reg     <= type_reg_next;
      size_reg     <= size_reg_next;
      value_acc    <= value_acc_next;
      count_reg    <= count_reg_next;
      stopped      <= stopped_next;
    end
  end

  // A second result only accompanies a record and is always the summary
  a_second_needs_first: assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> (push.v0 && push.r0.kind == tlvp_pkg::KIND_RECORD
                 && push.r1.kind == tlvp_pkg::KIND_SUMMARY))
    else $error("second result without a leading record");

  // Nothing comes out while draining a stopped buffer
  a_quiet_when_stopped: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !push.v0)
    else $error("result produced after parsing ended");

  // A summary always leaves the parser stopped or back at a header start
  a_summary_closes: assert property (@(posedge clk) disable iff (rst)
    (push.v0 && !push.v1 && push.r0.kind == tlvp_pkg::KIND_SUMMARY)
      |=> (stopped || phase == tlvp_pkg::PH_H0))
    else $error("summary did not close the buffer");

endmodule

/* design/tlvp_out_fifo.sv */
// Result queue: takes up to two results per cycle, gives one per transaction.
// Depends on tlvp_pkg.
module tlvp_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  tlvp_pkg::push_t               push,
  output logic                          room2,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tlvp_pkg::res_t                out_res
);

  tlvp_pkg::res_t                       entries [tlvp_pkg::FIFO_DEPTH];
  logic [tlvp_pkg::FIFO_AW-1:0]         wr_ptr, rd_ptr;
  logic [tlvp_pkg::FIFO_AW:0]           count, count_next;
  logic [tlvp_pkg::FIFO_AW-1:0]         wr_ptr1;
  logic                                 pop;
  logic [1:0]                           n_push;

  localparam logic [tlvp_pkg::FIFO_AW:0] DEPTH_C = (tlvp_pkg::FIFO_AW+1)'(tlvp_pkg::FIFO_DEPTH);

  assign pop       = out_valid & out_ready;
  assign out_valid = (count != '0);
  assign out_res   = entries[rd_ptr];
  assign room2     = (count <= DEPTH_C - 2'd2);
  assign wr_ptr1   = wr_ptr + 1'b1;
  assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};
  assign count_next = count + {{(tlvp_pkg::FIFO_AW-1){1'b0}}, n_push}
                      - {{tlvp_pkg::FIFO_AW{1'b0}}, pop};

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      entries[wr_ptr1] <= push.r1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + n_push[tlvp_pkg::FIFO_AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("result queue overflow");

  // Pushes only happen in a cycle where two entries are free
  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push.v0 || push.v1) |-> room2)
    else $error("results pushed without room");

endmodule

/* design/tlv_metadata_record_parser.sv */
// Top level of the TLV metadata record parser: stream ports and field packing.
// Depends on tlvp_pkg, tlvp_parser, tlvp_out_fifo.
//
// Takes one buffer byte per transaction, a byte every cycle while the output
// queue has two free entries (s_axis_tready high). Each byte is parsed in the
// cycle it is accepted; its results (none, one or two) are registered into a
// four-entry output queue and offered on the master side behind any earlier
// results. Results leave at one per transaction, so a byte that ends a record
// and the buffer together gives two output transactions. Record results carry
// tuser 0; the buffer summary carries tuser 1 and tlast 1.
module tlv_metadata_record_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tlast,   // buffer_end
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] record_type, [31:16] declared_size, [95:32] value, [96] known_type,
  // [112:97] record_count, [114:113] end_reason, [119:115] zero
  output logic [119:0] m_axis_tdata,
  output logic         m_axis_tuser,   // kind
  output logic         m_axis_tlast    // final_res
);

  tlvp_pkg::push_t push;
  tlvp_pkg::res_t  res;
  logic            room2;
  logic            in_fire;

  assign s_axis_tready = room2;
  assign in_fire       = s_axis_tvalid & room2;

  tlvp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .data_byte  (s_axis_tdata),
    .buffer_end (s_axis_tlast),
    .push       (push)
  );

  tlvp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room2     (room2),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Pack result fields
  assign m_axis_tdata = {5'd0, res.end_reason, res.record_count, res.known_type,
                         res.value, res.declared_size, res.record_type};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.final_res;

endmodule
